[rtl/lid_pkg.sv]
package lid_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_CHANNELS  = 8;
	localparam int DEF_SAMPLE_BITS   = 24;
	localparam int DEF_FRACTION_BITS = 24;

	// Fixed field widths
	localparam int RATIO_BITS     = 32;
	localparam int PHASE_BITS     = 32;
	localparam int COUNT_BITS     = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	// Channel count after reset
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(2);

	// Command queue between front and back
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_RATE_RATIO    = CFG_INDEX_BITS'(0),
		CFG_CHANNEL_COUNT = CFG_INDEX_BITS'(1)
	} cfg_reg_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

[rtl/lid_fifo.sv]
module lid_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  logic [WIDTH-1:0]        push_data,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output logic [WIDTH-1:0]        pop_data,
	output lid_pkg::fifo_status_t   status
);

	localparam int DEPTH = lid_pkg::FIFO_DEPTH;
	localparam int PW    = lid_pkg::FIFO_PTR_BITS;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      count_q;
	logic             push;
	logic             pop;

	// Status and handshake
	assign status.full  = (count_q == (PW+1)'(DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ready   = !status.full;
	assign pop_valid    = !status.empty;
	assign push         = push_valid && push_ready;
	assign pop          = pop_valid && pop_ready;
	assign pop_data     = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

[rtl/lid_front.sv]
module lid_front #(
	parameter int MAX_CHANNELS  = lid_pkg::DEF_MAX_CHANNELS,
	parameter int SAMPLE_BITS   = lid_pkg::DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = lid_pkg::DEF_FRACTION_BITS,
	parameter int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [lid_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lid_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                 op_valid,
	input  logic                                 op_ready,
	output logic signed [SAMPLE_BITS-1:0]        op_s0,
	output logic signed [SAMPLE_BITS:0]          op_diff,
	output logic [FRACTION_BITS-1:0]             op_frac,
	output logic [CH_W-1:0]                      op_chan,
	output logic                                 op_last
);

	localparam int RB = lid_pkg::RATIO_BITS;
	localparam int PB = lid_pkg::PHASE_BITS;
	localparam int NB = lid_pkg::COUNT_BITS;
	localparam int CLOG_MAX = $clog2(MAX_CHANNELS + 1);
	localparam int CW = ((NB > CLOG_MAX) ? NB : CLOG_MAX) + 1;
	localparam logic [PB:0] ONE = (PB+1)'(1) << FRACTION_BITS;

	logic [RB-1:0]                 rate_q;
	logic [NB-1:0]                 count_q;
	logic [PB-1:0]                 phase_q;
	logic [CH_W-1:0]               chan_q;
	logic                          primed_q;
	logic signed [SAMPLE_BITS-1:0] prev_q [MAX_CHANNELS];

	logic          lt_one;
	logic          emit;
	logic          accept;
	logic          last;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] next_ch;
	logic [PB:0]   ratio_eff;
	logic [PB+1:0] phase_sum;
	logic [PB+1:0] phase_next;

	// Classify the incoming word: does this frame produce output
	assign lt_one   = ({1'b0, phase_q} < ONE);
	assign emit     = primed_q && lt_one;
	assign in_ready = op_ready || !emit;
	assign accept   = in_valid && in_ready;
	assign op_valid = in_valid && emit;

	// Effective channel count, clamped to 1..MAX_CHANNELS
	assign cnt_ext = CW'(count_q);
	always_comb begin
		if (cnt_ext == '0) begin
			cnt_eff = CW'(1);
		end else if (cnt_ext > CW'(MAX_CHANNELS)) begin
			cnt_eff = CW'(MAX_CHANNELS);
		end else begin
			cnt_eff = cnt_ext;
		end
	end
	assign next_ch = CW'(chan_q) + CW'(1);
	assign last    = (next_ch >= cnt_eff);

	// Command word for the back end
	assign op_s0   = prev_q[chan_q];
	assign op_diff = {sample_in[SAMPLE_BITS-1], sample_in} - {op_s0[SAMPLE_BITS-1], op_s0};
	assign op_frac = phase_q[FRACTION_BITS-1:0];
	assign op_chan = chan_q;
	assign op_last = last;

	// Phase advance at frame end; ratio below 1.0 counts as 1.0
	assign ratio_eff = ({1'b0, rate_q} < ONE) ? ONE : {1'b0, rate_q};
	assign phase_sum = lt_one ? ({2'b0, phase_q} + {1'b0, ratio_eff}) : {2'b0, phase_q};
	assign phase_next = phase_sum - {1'b0, ONE};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= ONE[RB-1:0];
			count_q <= lid_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				lid_pkg::CFG_RATE_RATIO: begin
					rate_q <= cfg_data[RB-1:0];
				end
				lid_pkg::CFG_CHANNEL_COUNT: begin
					count_q <= cfg_data[NB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Stream state: phase, channel position, primed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			chan_q   <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				if (primed_q) begin
					phase_q <= phase_next[PB-1:0];
				end
				primed_q <= 1'b1;
				chan_q   <= '0;
			end else begin
				chan_q <= next_ch[CH_W-1:0];
			end
		end
	end

	// Previous sample of each channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (accept) begin
			prev_q[chan_q] <= sample_in;
		end
	end

endmodule

[rtl/lid_back.sv]
module lid_back #(
	parameter int SAMPLE_BITS   = lid_pkg::DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = lid_pkg::DEF_FRACTION_BITS,
	parameter int CH_W          = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	output logic                          op_ready,
	input  logic signed [SAMPLE_BITS-1:0] op_s0,
	input  logic signed [SAMPLE_BITS:0]   op_diff,
	input  logic [FRACTION_BITS-1:0]      op_frac,
	input  logic [CH_W-1:0]               op_chan,
	input  logic                          op_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [CH_W-1:0]               out_channel,
	output logic                          frame_end
);

	localparam int AW = SAMPLE_BITS + FRACTION_BITS + 2;

	logic                          v_s1;
	logic signed [SAMPLE_BITS-1:0] s0_s1;
	logic signed [AW-1:0]          prod_s1;
	logic [CH_W-1:0]               ch_s1;
	logic                          last_s1;
	logic                          v_s2;

	logic                          adv1;
	logic                          adv2;
	logic signed [FRACTION_BITS:0] frac_sgn;
	logic signed [AW-1:0]          prod;
	logic signed [AW-1:0]          acc;
	logic signed [AW-1:0]          quo;
	logic signed [AW-1:0]          res;

	// Stage advance
	assign adv2      = !v_s2 || out_ready;
	assign adv1      = !v_s1 || adv2;
	assign op_ready  = adv1;
	assign out_valid = v_s2;

	// Stage 1 product: (s1 - s0) * f
	assign frac_sgn = $signed({1'b0, op_frac});
	assign prod     = op_diff * frac_sgn;

	// Stage 2: s0 * 1.0 + product, divide by 1.0 rounding toward zero
	assign acc = (AW'(s0_s1) <<< FRACTION_BITS) + prod_s1;
	assign quo = acc >>> FRACTION_BITS;
	assign res = quo + AW'(acc[AW-1] && (|acc[FRACTION_BITS-1:0]));

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= op_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv1 && op_valid) begin
			s0_s1   <= op_s0;
			prod_s1 <= prod;
			ch_s1   <= op_chan;
			last_s1 <= op_last;
		end
		if (adv2 && v_s1) begin
			sample_out  <= res[SAMPLE_BITS-1:0];
			out_channel <= ch_s1;
			frame_end   <= last_s1;
		end
	end

endmodule

[rtl/linear_interp_downsampler.sv]
// Linear-interpolation downsampler, interleaved channels, Q8.24 ratio.
// Throughput: one input word per cycle, one output word per cycle, while out_ready is high and the queue is not full.
// Path of an accepted word: command queue write, multiply stage register,
// add/round into the output register; each step can stall on back-pressure.
// Reset (arst_n low, asynchronous): phase, channel position, primed flag and
// previous samples clear; ratio resets to 1.0 and channel count to 2.
module linear_interp_downsampler #(
	parameter int MAX_CHANNELS  = lid_pkg::DEF_MAX_CHANNELS,
	parameter int SAMPLE_BITS   = lid_pkg::DEF_SAMPLE_BITS,
	parameter int FRACTION_BITS = lid_pkg::DEF_FRACTION_BITS,
	parameter int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lid_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lid_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic [CH_W-1:0]                    out_channel,
	output logic                               frame_end
);

	localparam int OPW = 2 * SAMPLE_BITS + 1 + FRACTION_BITS + CH_W + 1;

	logic                          f_valid;
	logic                          f_ready;
	logic signed [SAMPLE_BITS-1:0] f_s0;
	logic signed [SAMPLE_BITS:0]   f_diff;
	logic [FRACTION_BITS-1:0]      f_frac;
	logic [CH_W-1:0]               f_chan;
	logic                          f_last;
	logic [OPW-1:0]                q_wdata;
	logic [OPW-1:0]                q_rdata;
	logic                          b_valid;
	logic                          b_ready;
	logic signed [SAMPLE_BITS-1:0] b_s0;
	logic signed [SAMPLE_BITS:0]   b_diff;
	logic [FRACTION_BITS-1:0]      b_frac;
	logic [CH_W-1:0]               b_chan;
	logic                          b_last;
	lid_pkg::fifo_status_t         fifo_st;

	// Configuration writes always taken
	assign cfg_ready = 1'b1;

	// Front: accepts words, tracks phase, issues interpolation commands
	lid_front #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.CH_W          (CH_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op_s0     (f_s0),
		.op_diff   (f_diff),
		.op_frac   (f_frac),
		.op_chan   (f_chan),
		.op_last   (f_last)
	);

	// Command queue
	assign q_wdata = {f_s0, f_diff, f_frac, f_chan, f_last};
	assign {b_s0, b_diff, b_frac, b_chan, b_last} = q_rdata;

	lid_fifo #(
		.WIDTH (OPW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_wdata),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_rdata),
		.status     (fifo_st)
	);

	// Back: multiply, add and round, output register
	lid_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.CH_W          (CH_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (b_valid),
		.op_ready    (b_ready),
		.op_s0       (b_s0),
		.op_diff     (b_diff),
		.op_frac     (b_frac),
		.op_chan     (b_chan),
		.op_last     (b_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.out_channel (out_channel),
		.frame_end   (frame_end)
	);

	// Queue can never report full and empty together
	a_fifo_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_st.full && fifo_st.empty))
		else $error("command queue full and empty at once");

	// An accepted word that needs output never meets a full queue
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && f_valid) |-> !fifo_st.full)
		else $error("output command dropped on full queue");

	// A word pushed into an empty queue is visible to the back end next cycle
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && f_ready && fifo_st.empty) |=> b_valid)
		else $error("queued command not presented to back end");

	// Channel index stays in range
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_channel} < (CH_W+1)'(MAX_CHANNELS)))
		else $error("output channel out of range");

endmodule
